@@ rtl/mpps_pkg.sv @@
// ============================================================================
// mpps_pkg: shared constants and types for the process scheduler
// Sizes, command and mode codes, controller states and the control bundle
// between the scheduler controller and its datapath.
// ============================================================================
`default_nettype none

package mpps_pkg;

  localparam int NUM_PROCESSES = 4;
  localparam int PRIORITY_BITS = 8;
  localparam int SHARE_BITS    = 8;
  localparam int RANDOM_TRIES  = 16;

  localparam int ID_W  = $clog2(NUM_PROCESSES + 1);
  localparam int IDX_W = $clog2(NUM_PROCESSES);

  localparam int CMD_W      = 2;
  localparam int ARG_W      = 8;
  localparam int RUN_W      = 3;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam int GEN_W  = 32;
  localparam int HALF_W = 16;
  localparam logic [HALF_W-1:0] MWC_MULT = 16'd36969;
  localparam logic [HALF_W-1:0] MWC_LOW  = 16'd65535;

  // share scan needs NUM_PROCESSES+2 passes, random needs RANDOM_TRIES draws
  localparam int ITER_MAX = (RANDOM_TRIES > NUM_PROCESSES + 2) ? RANDOM_TRIES
                                                               : NUM_PROCESSES + 2;
  localparam int ITER_W   = $clog2(ITER_MAX);

  localparam logic [CMD_W-1:0] CMD_SCHEDULE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET_SHARE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_RR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOWEST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHARE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;    // latch the incoming event
    logic step;      // run one scheduling pass
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // current pass finishes the event
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/mpps_ctrl.sv @@
// ============================================================================
// mpps_ctrl: scheduler sequencer
// Takes one event, steps the datapath until it reports a result, then hands
// the result to the output register when that register is free.
// ============================================================================
`default_nettype none

module mpps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire mpps_pkg::dp_sts_t sts,
  output mpps_pkg::dp_cmd_t     cmd
);

  mpps_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpps_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mpps_pkg::S_RUN;
      end
      mpps_pkg::S_RUN: begin
        if (sts.done) state_nxt = mpps_pkg::S_DONE;
      end
      mpps_pkg::S_DONE: begin
        if (slot_free) state_nxt = mpps_pkg::S_IDLE;
      end
      default: state_nxt = mpps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      mpps_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      mpps_pkg::S_RUN: begin
        cmd.step = 1'b1;
      end
      mpps_pkg::S_DONE: begin
        cmd.load_out = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpps_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mpps_dp.sv @@
// ============================================================================
// mpps_dp: scheduler datapath
// Holds the run mask, priority and share tables, rotation state and the
// random generator; evaluates one scheduling pass per step.
// ============================================================================
`default_nettype none

module mpps_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mpps_pkg::dp_cmd_t                   cmd,
  output mpps_pkg::dp_sts_t                        sts,
  input  wire logic [mpps_pkg::CMD_W-1:0]          in_command,
  input  wire logic [mpps_pkg::ARG_W-1:0]          in_argument,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mpps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mpps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic      [mpps_pkg::RUN_W-1:0]          out_run_id,
  output logic                                     out_none_runnable
);

  localparam int N     = mpps_pkg::NUM_PROCESSES;
  localparam int ID_W  = mpps_pkg::ID_W;
  localparam int IDX_W = mpps_pkg::IDX_W;
  localparam int PB    = mpps_pkg::PRIORITY_BITS;
  localparam int SB    = mpps_pkg::SHARE_BITS;
  localparam int IT_W  = mpps_pkg::ITER_W;
  localparam int GW    = mpps_pkg::GEN_W;
  localparam int HW    = mpps_pkg::HALF_W;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic in_mask(logic [N-1:0] m, logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - ID_W'(1);
    return (id != '0) && (id <= ID_W'(N)) && m[t[IDX_W-1:0]];
  endfunction

  // first id in m after start, wrapping; start itself comes last
  function automatic logic [ID_W-1:0] first_after(logic [N-1:0] m, logic [ID_W-1:0] start);
    logic [ID_W-1:0] s;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] res;
    logic [ID_W:0]   sum;
    s   = (start > ID_W'(N)) ? '0 : start;
    res = '0;
    for (int k = N; k >= 1; k--) begin
      sum = {1'b0, s} + (ID_W+1)'(k - 1);
      if (sum >= (ID_W+1)'(N)) sum = sum - (ID_W+1)'(N);
      id = sum[ID_W-1:0] + ID_W'(1);
      if (in_mask(m, id)) res = id;
    end
    return res;
  endfunction

  function automatic logic [PB-1:0] sat_prio(logic [mpps_pkg::ARG_W-1:0] a);
    logic [PB-1:0] v;
    if (PB < mpps_pkg::ARG_W && (a >> PB) != '0) v = '1;
    else v = PB'(a);
    return v;
  endfunction

  function automatic logic [SB-1:0] sat_share(logic [mpps_pkg::ARG_W-1:0] a);
    logic [SB-1:0] v;
    if (SB < mpps_pkg::ARG_W && (a >> SB) != '0) v = '1;
    else v = SB'(a);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  logic [mpps_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [N-1:0]                mask_r, mask_nxt;
  logic [PB-1:0]               prio_r  [N];
  logic [PB-1:0]               prio_nxt[N];
  logic [SB-1:0]               share_r  [N];
  logic [SB-1:0]               share_nxt[N];
  logic [ID_W-1:0]             cur_r, cur_nxt;
  logic [ID_W-1:0]             rp_r, rp_nxt;
  logic [SB-1:0]               q_r, q_nxt;
  logic [GW-1:0]               gen_r, gen_nxt;
  logic [mpps_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [mpps_pkg::ARG_W-1:0]  arg_r, arg_nxt;
  logic [IT_W-1:0]             iter_r, iter_nxt;
  logic [ID_W-1:0]             res_run_r, res_run_nxt;
  logic                        res_none_r, res_none_nxt;
  logic [mpps_pkg::RUN_W-1:0]  out_run_r, out_run_nxt;
  logic                        out_none_r, out_none_nxt;

  // --------------------------------------------------------------------------
  // pass evaluation
  // --------------------------------------------------------------------------
  logic [PB-1:0]   best;
  logic [N-1:0]    cand;
  logic            rp_oor, reload;
  logic [ID_W-1:0] rp_b, rp_bi, rp_inc, cur_i;
  logic [SB-1:0]   share_rd, q_b;
  logic [GW-1:0]   prod, gen_new;
  logic [ID_W-1:0] draw_r, draw_id;
  logic [ID_W-1:0] pick;
  logic            picked;
  logic            cur_ok;
  logic            done;

  always_comb begin
    best = '0;
    for (int i = 0; i < N; i++) begin
      if (mask_r[i] && prio_r[i] > best) best = prio_r[i];
    end
    for (int i = 0; i < N; i++) begin
      cand[i] = mask_r[i] && (prio_r[i] == best);
    end
  end

  always_comb begin
    rp_oor   = (rp_r == '0) || (rp_r > ID_W'(N));
    reload   = rp_oor || (q_r == '0);
    rp_inc   = (rp_r >= ID_W'(N)) ? ID_W'(1) : rp_r + ID_W'(1);
    rp_b     = rp_oor ? ID_W'(1) : ((q_r == '0) ? rp_inc : rp_r);
    rp_bi    = rp_b - ID_W'(1);
    share_rd = share_r[rp_bi[IDX_W-1:0]];
    // a zero share counts as one quantum
    if (reload) q_b = (share_rd == '0) ? SB'(1) : share_rd;
    else q_b = q_r;
  end

  // multiply-with-carry generator
  assign prod    = GW'(mpps_pkg::MWC_MULT) * GW'(gen_r[HW-1:0] & mpps_pkg::MWC_LOW);
  assign gen_new = prod + GW'(gen_r[GW-1:HW]);
  assign draw_r  = ID_W'(gen_new % N);
  assign draw_id = (draw_r == '0) ? ID_W'(N) : draw_r;

  assign cur_ok = in_mask('1, cur_r);
  assign cur_i  = cur_r - ID_W'(1);

  always_comb begin
    mode_nxt     = mode_r;
    mask_nxt     = mask_r;
    prio_nxt     = prio_r;
    share_nxt    = share_r;
    cur_nxt      = cur_r;
    rp_nxt       = rp_r;
    q_nxt        = q_r;
    gen_nxt      = gen_r;
    cmd_nxt      = cmd_r;
    arg_nxt      = arg_r;
    iter_nxt     = iter_r;
    res_run_nxt  = res_run_r;
    res_none_nxt = res_none_r;
    out_run_nxt  = out_run_r;
    out_none_nxt = out_none_r;
    pick         = '0;
    picked       = 1'b0;
    done         = 1'b0;

    if (cmd.accept) begin
      cmd_nxt  = in_command;
      arg_nxt  = in_argument;
      iter_nxt = '0;
      // exit drops the running process before the pick
      if (in_command == mpps_pkg::CMD_EXIT && cur_ok) begin
        mask_nxt = mask_r & ~(N'(1) << cur_i[IDX_W-1:0]);
      end
    end

    if (cmd.step) begin
      if (cmd_r == mpps_pkg::CMD_SET_PRIO || cmd_r == mpps_pkg::CMD_SET_SHARE) begin
        done = 1'b1;
        if (cur_ok) begin
          if (cmd_r == mpps_pkg::CMD_SET_PRIO) prio_nxt[cur_i[IDX_W-1:0]] = sat_prio(arg_r);
          else share_nxt[cur_i[IDX_W-1:0]] = sat_share(arg_r);
          res_run_nxt  = cur_r;
          res_none_nxt = 1'b0;
        end else begin
          res_run_nxt  = '0;
          res_none_nxt = (mask_r == '0);
        end
      end else if (mask_r == '0) begin
        done         = 1'b1;
        cur_nxt      = '0;
        res_run_nxt  = '0;
        res_none_nxt = 1'b1;
      end else begin
        unique case (mode_r)
          mpps_pkg::MODE_LOWEST: begin
            pick   = first_after(mask_r, '0);
            picked = 1'b1;
          end
          mpps_pkg::MODE_PRIO: begin
            pick   = first_after(cand, rp_r);
            rp_nxt = pick;
            picked = 1'b1;
          end
          mpps_pkg::MODE_SHARE: begin
            rp_nxt = rp_b;
            if (in_mask(mask_r, rp_b)) begin
              q_nxt  = q_b - SB'(1);
              pick   = rp_b;
              picked = 1'b1;
            end else begin
              // a stopped process under the pointer forfeits its quanta
              q_nxt    = '0;
              iter_nxt = iter_r + IT_W'(1);
              if (iter_r == IT_W'(N + 1)) begin
                pick   = first_after(mask_r, '0);
                picked = 1'b1;
              end
            end
          end
          mpps_pkg::MODE_RANDOM: begin
            gen_nxt = gen_new;
            if (in_mask(mask_r, draw_id)) begin
              pick   = draw_id;
              picked = 1'b1;
            end else begin
              iter_nxt = iter_r + IT_W'(1);
              if (iter_r == IT_W'(mpps_pkg::RANDOM_TRIES - 1)) begin
                pick   = first_after(mask_r, draw_id);
                picked = 1'b1;
              end
            end
          end
          default: begin
            pick   = first_after(mask_r, cur_r);
            picked = 1'b1;
          end
        endcase
        if (picked) begin
          done         = 1'b1;
          cur_nxt      = pick;
          res_run_nxt  = pick;
          res_none_nxt = 1'b0;
        end
      end
    end

    if (cfg_wr_en) begin
      if (cfg_index == mpps_pkg::CFG_POLICY_MODE) begin
        mode_nxt = cfg_wdata[mpps_pkg::MODE_W-1:0];
      end else if (cfg_index == mpps_pkg::CFG_RANDOM_SEED) begin
        gen_nxt = cfg_wdata[GW-1:0];
      end
    end

    if (cmd.load_out) begin
      out_run_nxt  = mpps_pkg::RUN_W'(res_run_r);
      out_none_nxt = res_none_r;
    end
  end

  assign sts.done          = done;
  assign out_run_id        = out_run_r;
  assign out_none_runnable = out_none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mpps_pkg::MODE_RR;
      mask_r  <= '1;
      cur_r   <= '0;
      rp_r    <= '0;
      q_r     <= '0;
      gen_r   <= GW'(1);
      for (int i = 0; i < N; i++) begin
        prio_r[i]  <= '0;
        share_r[i] <= '0;
      end
    end else begin
      mode_r  <= mode_nxt;
      mask_r  <= mask_nxt;
      cur_r   <= cur_nxt;
      rp_r    <= rp_nxt;
      q_r     <= q_nxt;
      gen_r   <= gen_nxt;
      prio_r  <= prio_nxt;
      share_r <= share_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    arg_r      <= arg_nxt;
    iter_r     <= iter_nxt;
    res_run_r  <= res_run_nxt;
    res_none_r <= res_none_nxt;
    out_run_r  <= out_run_nxt;
    out_none_r <= out_none_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/multi_policy_process_scheduler.sv @@
// ============================================================================
// multi_policy_process_scheduler: picks the next of four processes to run
//
// Input stream (in_*): one scheduling event per transfer: schedule, exit of
// the running process, set its priority or set its share. Output stream
// (out_*): one result per event, the id to run (1..4, 0 for none) and a
// flag that is set when no process is runnable.
// Config port: cfg_index 0 writes the policy mode, 1 writes the random seed
// (which also reloads the generator). Write only while no event is in flight.
// The event is taken in the idle state, its passes run in the run state
// and the done state loads the output register when that register is free.
// Round robin, lowest id, priority and set commands take one pass; share
// mode walks one process per cycle (up to 6 passes); random mode makes one
// generator draw per cycle (up to 16 passes). One event is worked at a time.
// The output register frees the input side: a new event is taken while an
// earlier result waits; a finished result stalls only when the previous one
// has not been taken yet.
// Reset (rst_n low, synchronous): all processes runnable, tables zero, no
// process running, round robin mode, generator state one, no result valid.
// ============================================================================
`default_nettype none

module multi_policy_process_scheduler (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [1:0] command, [9:2] argument
  input  wire logic [mpps_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] run_id, [3] none_runnable
  output logic      [mpps_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mpps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mpps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = mpps_pkg::CMD_W;
  localparam int AW = mpps_pkg::ARG_W;
  localparam int RW = mpps_pkg::RUN_W;

  mpps_pkg::dp_cmd_t dp_cmd;
  mpps_pkg::dp_sts_t dp_sts;
  logic [RW-1:0]     run_id;
  logic              none_runnable;

  mpps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  mpps_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .sts               (dp_sts),
    .in_command        (in_tdata[CW-1:0]),
    .in_argument       (in_tdata[CW+AW-1:CW]),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_run_id        (run_id),
    .out_none_runnable (none_runnable)
  );

  assign out_tdata = {{(mpps_pkg::OUT_DATA_W-RW-1){1'b0}}, none_runnable, run_id};

endmodule

`default_nettype wire

@@ rtl/mpps_chk.sv @@
// ============================================================================
// mpps_chk: port-level checks for the process scheduler
// Watches the stream ports and flags results or handshakes that the
// scheduler can never produce.
// ============================================================================
`default_nettype none

module mpps_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [mpps_pkg::OUT_DATA_W-1:0] out_tdata
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one event in flight: no back-to-back input transfers
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an event is in flight");

  // empty run set always reports id zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2:0] == 3'd0)
    else $error("none_runnable with a nonzero run id");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'(mpps_pkg::NUM_PROCESSES))
    else $error("run id out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind multi_policy_process_scheduler mpps_chk u_mpps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
